FILE: sv/rcd_pkg.sv
// Shared types, constants and the EDC byte update for the raw CD sector deframer.
// Depends on nothing; imported by every module of the block.
package rcd_pkg;

  localparam int unsigned SECTOR_BYTES    = 2352;
  localparam int unsigned EDC_START       = 16;
  localparam int unsigned PAYLOAD_START   = 24;
  localparam int unsigned PAYLOAD_BYTES   = 2324;
  localparam int unsigned EDC_FIELD_BYTES = 4;
  localparam int unsigned POS_W           = 12;

  localparam logic [POS_W-1:0] POS_EDC_START = POS_W'(EDC_START);
  localparam logic [POS_W-1:0] POS_PAY_FIRST = POS_W'(PAYLOAD_START);
  localparam logic [POS_W-1:0] POS_PAY_LAST  = POS_W'(PAYLOAD_START + PAYLOAD_BYTES - 1);
  localparam logic [POS_W-1:0] POS_FIELD     = POS_W'(SECTOR_BYTES - EDC_FIELD_BYTES);
  localparam logic [POS_W-1:0] POS_FINAL     = POS_W'(SECTOR_BYTES - 1);

  localparam logic [31:0] EDC_POLY = 32'hD801_8001;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] EDC_GOOD   = 2'd0;
  localparam logic [1:0] EDC_ABSENT = 2'd1;
  localparam logic [1:0] EDC_BAD    = 2'd2;

  typedef struct packed {
    logic       has;
    logic       kind;
    logic [7:0] data;
    logic       last;
    logic [1:0] status;
  } rcd_result_t;

  function automatic logic [31:0] edc_update(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] r;
    r = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ EDC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

FILE: sv/rcd_sector_track.sv
// Sector position counter, running EDC and field-zero flag; forms data/status results.
// Depends on rcd_pkg.
module rcd_sector_track
  import rcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic [7:0]  sector_byte,
  output rcd_result_t result
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [31:0]      rem_r, rem_nxt;
  logic             fz_r, fz_nxt;
  logic             final_byte;

  always_comb begin
    final_byte = (pos_r == POS_FINAL);
    rem_nxt    = (pos_r >= POS_EDC_START) ? edc_update(rem_r, sector_byte) : rem_r;
    fz_nxt     = fz_r & ((pos_r < POS_FIELD) | (sector_byte == 8'd0));

    result = '0;
    if (pos_r >= POS_PAY_FIRST && pos_r <= POS_PAY_LAST) begin
      result.has  = 1'b1;
      result.kind = KIND_DATA;
      result.data = sector_byte;
      result.last = (pos_r == POS_PAY_LAST);
    end
    if (final_byte) begin
      result.has  = 1'b1;
      result.kind = KIND_STATUS;
      result.data = 8'd0;
      result.last = 1'b0;
      priority if (fz_nxt) begin
        result.status = EDC_ABSENT;
      end else if (rem_nxt == 32'd0) begin
        result.status = EDC_GOOD;
      end else begin
        result.status = EDC_BAD;
      end
    end

    pos_nxt = final_byte ? '0 : pos_r + POS_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      rem_r <= '0;
      fz_r  <= 1'b1;
    end else if (adv) begin
      pos_r <= pos_nxt;
      rem_r <= final_byte ? 32'd0 : rem_nxt;
      fz_r  <= final_byte ? 1'b1 : fz_nxt;
    end
  end

endmodule

FILE: sv/rcd_out_reg.sv
// Result register with valid/ready toward the consumer.
// Depends on rcd_pkg.
module rcd_out_reg
  import rcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  rcd_result_t result,
  output logic        free,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [7:0]  out_data_byte,
  output logic        out_data_last,
  output logic [1:0]  out_edc_status
);

  logic       valid_r, valid_nxt;
  logic       kind_r;
  logic [7:0] data_r;
  logic       last_r;
  logic [1:0] status_r;

  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r && !out_ready;
    if (load) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r   <= result.kind;
      data_r   <= result.data;
      last_r   <= result.last;
      status_r <= result.status;
    end
  end

  assign out_valid       = valid_r;
  assign out_result_kind = kind_r;
  assign out_data_byte   = data_r;
  assign out_data_last   = last_r;
  assign out_edc_status  = status_r;

endmodule

FILE: sv/raw_cd_sector_edc_deframer.sv
// Top level of the raw CD-XA mode 2 sector deframer with EDC check.
// Depends on rcd_pkg, rcd_sector_track and rcd_out_reg.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------------
//   in       | in_valid / in_ready  | in_sector_byte[7:0]
//   out      | out_valid / out_ready| out_result_kind, out_data_byte[7:0],
//            |                      | out_data_last, out_edc_status[1:0]
//
// One word per cycle while no held result blocks it; a word is registered in the input
// register and then enters the result register through the byte-wide EDC update.
// Reset (rst_n low, synchronous) empties both registers and starts a new sector.
// A held result stalls the input register only when that register's word also
// needs the result register; words that make no result pass through regardless.
module raw_cd_sector_edc_deframer
  import rcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_sector_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_result_kind,
  output logic [7:0] out_data_byte,
  output logic       out_data_last,
  output logic [1:0] out_edc_status
);

  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_byte_r;
  logic        s1_adv;
  logic        out_free;
  rcd_result_t result;

  assign s1_adv   = s1_valid_r && (out_free || !result.has);
  assign in_ready = !s1_valid_r || s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r && !s1_adv;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_sector_byte;
    end
  end

  rcd_sector_track u_track (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (s1_adv),
    .sector_byte (s1_byte_r),
    .result      (result)
  );

  rcd_out_reg u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (s1_adv && result.has),
    .result          (result),
    .free            (out_free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_data_byte   (out_data_byte),
    .out_data_last   (out_data_last),
    .out_edc_status  (out_edc_status)
  );

endmodule

FILE: sv/rcd_checker.sv
// Port-level checks for raw_cd_sector_edc_deframer, attached by bind.
// Depends on rcd_pkg.
module rcd_checker
  import rcd_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_result_kind,
  input logic [7:0] out_data_byte,
  input logic       out_data_last,
  input logic [1:0] out_edc_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_byte)
      && $stable(out_result_kind) && $stable(out_edc_status))
    else $error("result word dropped or changed while stalled");

  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_STATUS |-> out_data_byte == 8'd0 && !out_data_last)
    else $error("status word carries data");

  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_DATA |-> out_edc_status == EDC_GOOD)
    else $error("data word carries a status");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_edc_status == EDC_GOOD || out_edc_status == EDC_ABSENT
      || out_edc_status == EDC_BAD)
    else $error("undefined status code");

endmodule

bind raw_cd_sector_edc_deframer rcd_checker u_rcd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_result_kind (out_result_kind),
  .out_data_byte   (out_data_byte),
  .out_data_last   (out_data_last),
  .out_edc_status  (out_edc_status)
);

FILE: bench/tb.sv
// Testbench for raw_cd_sector_edc_deframer: streams one raw sector with a valid EDC
// and checks every output word against a behavioral model of the deframer.
// Depends on rcd_pkg and the deframer RTL.
module tb;
  import rcd_pkg::*;

  localparam int unsigned LIMIT       = 1_000_000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef enum int {SEC_ZERO, SEC_ONES, SEC_GOOD, SEC_ABSENT, SEC_BAD, SEC_NOISE} sector_flavor_t;

  typedef struct {
    logic [7:0]  b;
    int unsigned phase;
    bit          hold;
  } raw_word_t;

  typedef struct {
    logic       kind;
    logic [7:0] data;
    logic       last;
    logic [1:0] status;
  } deframed_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_sector_byte = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_result_kind;
  logic [7:0] out_data_byte;
  logic       out_data_last;
  logic [1:0] out_edc_status;

  raw_word_t   raw_bytes_pending[$];
  deframed_t   sector_results_due[$];
  int unsigned send_idle_pct[3] = '{6, 76, 0};
  int unsigned recv_idle_pct[3] = '{76, 6, 0};
  int unsigned taken = 0;
  int unsigned shown = 0;
  int unsigned total_words = 0;
  int unsigned cur_phase = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  logic [POS_W-1:0] sec_pos = '0;
  logic [31:0]      edc_acc = '0;
  bit               edc_field_clear = 1'b1;

  raw_cd_sector_edc_deframer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sector_byte (in_sector_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_result_kind(out_result_kind),
    .out_data_byte  (out_data_byte),
    .out_data_last  (out_data_last),
    .out_edc_status (out_edc_status)
  );

  function automatic logic [31:0] edc_next(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] s;
    s = c;
    for (int i = 0; i < 8; i++) begin
      s = {1'b0, s[31:1]} ^ ((s[0] ^ b[i]) ? EDC_POLY : 32'd0);
    end
    return s;
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    deframed_t r;
    bit        emit;
    emit = 1'b0;
    r = '{KIND_DATA, b, 1'b0, EDC_GOOD};
    if (sec_pos >= POS_EDC_START) edc_acc = edc_next(edc_acc, b);
    if (sec_pos >= POS_FIELD && b != 8'd0) edc_field_clear = 1'b0;
    if (sec_pos >= POS_PAY_FIRST && sec_pos <= POS_PAY_LAST) begin
      r.last = (sec_pos == POS_PAY_LAST);
      emit = 1'b1;
    end
    if (sec_pos >= POS_FINAL) begin
      r.kind = KIND_STATUS;
      r.data = 8'd0;
      r.last = 1'b0;
      r.status = edc_field_clear ? EDC_ABSENT : ((edc_acc == 32'd0) ? EDC_GOOD : EDC_BAD);
      emit = 1'b1;
      sec_pos = '0;
      edc_acc = '0;
      edc_field_clear = 1'b1;
    end else begin
      sec_pos = sec_pos + 1'b1;
    end
    if (emit) sector_results_due.push_back(r);
  endfunction

  task automatic add_sector(input sector_flavor_t flavor);
    logic [7:0]  sec[SECTOR_BYTES];
    logic [31:0] crc;
    int unsigned k;
    raw_word_t   w;
    crc = '0;
    for (int i = 0; i < SECTOR_BYTES; i++) begin
      case (flavor)
        SEC_ZERO: sec[i] = 8'h00;
        SEC_ONES: sec[i] = 8'hFF;
        default:  sec[i] = 8'($urandom);
      endcase
    end
    if (flavor == SEC_ONES || flavor == SEC_GOOD || flavor == SEC_BAD) begin
      for (int i = EDC_START; i < SECTOR_BYTES - EDC_FIELD_BYTES; i++) begin
        crc = edc_next(crc, sec[i]);
      end
      for (int i = 0; i < EDC_FIELD_BYTES; i++) begin
        sec[SECTOR_BYTES - EDC_FIELD_BYTES + i] = crc[8*i +: 8];
      end
    end
    if (flavor == SEC_ABSENT) begin
      for (int i = SECTOR_BYTES - EDC_FIELD_BYTES; i < SECTOR_BYTES; i++) sec[i] = 8'h00;
    end
    if (flavor == SEC_BAD) begin
      k = $urandom_range(SECTOR_BYTES - 1);
      sec[k] ^= 8'(1 << $urandom_range(7));
    end
    for (int i = 0; i < SECTOR_BYTES; i++) begin
      w.b = sec[i];
      w.phase = (3 * i) / SECTOR_BYTES;
      w.hold = (i == 1000) || (i == 1800);
      raw_bytes_pending.push_back(w);
    end
  endtask

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    add_sector(SEC_GOOD);
    total_words = raw_bytes_pending.size();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (taken != total_words || sector_results_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct[cur_phase]);
      if (!(in_valid && shown == taken)) begin
        if (raw_bytes_pending.size() == 0
            || (raw_bytes_pending[0].hold && sector_results_due.size() != 0)
            || $urandom_range(99) < send_idle_pct[raw_bytes_pending[0].phase]) begin
          in_valid <= 1'b0;
          in_sector_byte <= 8'($urandom);
        end else begin
          in_valid <= 1'b1;
          in_sector_byte <= raw_bytes_pending[0].b;
          cur_phase <= raw_bytes_pending[0].phase;
          shown <= taken;
        end
      end
    end
  end

  always @(posedge clk) begin
    deframed_t got;
    deframed_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        deframe_byte(in_sector_byte);
        void'(raw_bytes_pending.pop_front());
        taken++;
      end
      if (out_valid && out_ready) begin
        got = '{out_result_kind, out_data_byte, out_data_last, out_edc_status};
        if (sector_results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected word: kind %0d data %02h last %0d status %0d",
                     got.kind, got.data, got.last, got.status);
        end else begin
          want = sector_results_due.pop_front();
          if (got.kind !== want.kind || got.data !== want.data
              || got.last !== want.last || got.status !== want.status) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"mismatch: expected kind %0d data %02h last %0d status %0d,",
                        " got kind %0d data %02h last %0d status %0d"},
                       want.kind, want.data, want.last, want.status,
                       got.kind, got.data, got.last, got.status);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

endmodule
